// ===== rtl/accumulated_pixel_srgb_encoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel sRGB encoder
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATED_PIXEL_SRGB_ENCODER_TOP_MACROS_SVH
`define ACCUMULATED_PIXEL_SRGB_ENCODER_TOP_MACROS_SVH

// explicit clock and active-low reset
`define APSE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default clock clk_i and reset rst_ni
`define APSE_ASSERT(lbl, prop, msg) `APSE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/apse_pkg.sv =====
// ----------------------------------------------------------------------------
// apse_pkg
// Widths, constants and the sRGB threshold table of the pixel encoder.
// ----------------------------------------------------------------------------
package apse_pkg;

  localparam int INPUT_FRACTION_BITS = 16;

  localparam int SUM_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CODE_W    = 8;
  localparam int NUM_CODES = (1 << CODE_W) - 1;

  // reciprocal of the sample count, Q1.24
  localparam int RECIP_FRAC = 24;
  localparam int RECIP_W    = RECIP_FRAC + 1;
  localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_FRAC;
  localparam int DIV_STEPS  = RECIP_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam int PROD_W   = SUM_W + RECIP_W + 1;
  localparam int LIN_W    = 16;
  localparam int LIN_LSB  = INPUT_FRACTION_BITS + CODE_W;
  localparam int THRESH_W = LIN_W + 1;
  localparam int BIG_W    = 240;

  typedef struct packed {
    logic               busy;
    logic [RECIP_W-1:0] recip;
  } div_status_t;

  // exact test: srgb(lin / 65536) >= k / 256
  function automatic logic srgb_reaches(logic [THRESH_W-1:0] lin, logic [CODE_W-1:0] k);
    logic [63:0]      l;
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    l   = 64'(lin);
    lhs = BIG_W'(1);
    rhs = BIG_W'(1);
    if (l * 64'd10000000 <= 64'd2051801088) begin
      return (l * 64'd1292 >= 64'(k) * 64'd25600);
    end
    for (int i = 0; i < 5; i++) begin
      lhs = lhs * BIG_W'(lin);
      rhs = rhs * BIG_W'(65536);
    end
    for (int i = 0; i < 12; i++) begin
      lhs = lhs * BIG_W'(6752);
      rhs = rhs * (BIG_W'(k) * BIG_W'(25) + BIG_W'(352));
    end
    return (lhs >= rhs);
  endfunction

  function automatic logic [NUM_CODES:0][THRESH_W-1:0] build_thresh();
    logic [NUM_CODES:0][THRESH_W-1:0] t;
    logic [THRESH_W:0]                lo;
    logic [THRESH_W:0]                hi;
    logic [THRESH_W:0]                mid;
    t = '0;
    for (int k = 1; k <= NUM_CODES; k++) begin
      lo = '0;
      hi = (THRESH_W+1)'(1) << LIN_W;
      for (int s = 0; s <= LIN_W; s++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (srgb_reaches(mid[THRESH_W-1:0], CODE_W'(k))) begin
            hi = mid;
          end else begin
            lo = mid + (THRESH_W+1)'(1);
          end
        end
      end
      t[k] = lo[THRESH_W-1:0];
    end
    return t;
  endfunction

  localparam logic [NUM_CODES:0][THRESH_W-1:0] THRESH = build_thresh();

endpackage

// ===== rtl/apse_recip_div.sv =====
// ----------------------------------------------------------------------------
// apse_recip_div
// Radix-2 restoring divider: floor(2^24 / count) on a configuration write.
// ----------------------------------------------------------------------------
module apse_recip_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [apse_pkg::CFG_W-1:0]  cfg_data_i,
  output apse_pkg::div_status_t       status_o
);
  import apse_pkg::*;

  logic               run_q, run_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [RECIP_W-1:0] recip_q, recip_d;
  logic [CFG_W-1:0]   div_q, div_d;
  logic [CFG_W-1:0]   rem_q, rem_d;
  logic [RECIP_W-1:0] quo_q, quo_d;
  logic               load;
  logic [CFG_W:0]     trial;
  logic               qbit;

  assign load  = cfg_valid_i && !run_q;
  assign trial = {rem_q, (cnt_q == CNT_W'(DIV_STEPS - 1))};
  assign qbit  = (trial >= {1'b0, div_q});

  always_comb begin
    run_d   = run_q;
    cnt_d   = cnt_q;
    recip_d = recip_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (load) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(DIV_STEPS - 1);
      div_d = (cfg_data_i == '0) ? CFG_W'(1) : cfg_data_i;
      rem_d = '0;
      quo_d = '0;
    end else if (run_q) begin
      rem_d = qbit ? CFG_W'(trial - {1'b0, div_q}) : trial[CFG_W-1:0];
      quo_d = {quo_q[RECIP_W-2:0], qbit};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        run_d   = 1'b0;
        recip_d = quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cnt_q   <= '0;
      recip_q <= RECIP_ONE;
    end else begin
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      recip_q <= recip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign status_o.busy  = run_q;
  assign status_o.recip = recip_q;

endmodule

// ===== rtl/apse_chan.sv =====
// ----------------------------------------------------------------------------
// apse_chan
// One colour channel: average by multiply, clamp, sRGB threshold search.
// ----------------------------------------------------------------------------
module apse_chan (
  input  logic                               clk_i,
  input  logic signed [apse_pkg::SUM_W-1:0]  sum_i,
  input  logic [apse_pkg::RECIP_W-1:0]       recip_i,
  output logic [apse_pkg::CODE_W-1:0]        code_o
);
  import apse_pkg::*;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [LIN_W-1:0]         lin;
  logic [NUM_CODES:0]       ge;
  logic [CODE_W-1:0]        idx;
  logic [CODE_W-1:0]        cand;
  logic [CODE_W-1:0]        code_q;

  assign prod_d = PROD_W'(sum_i) * PROD_W'($signed({1'b0, recip_i}));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    if (prod_q[PROD_W-1]) begin
      lin = '0;
    end else if (|prod_q[PROD_W-2:LIN_LSB+LIN_W]) begin
      lin = '1;
    end else begin
      lin = prod_q[LIN_LSB +: LIN_W];
    end
  end

  assign ge[0] = 1'b1;
  for (genvar k = 1; k <= NUM_CODES; k++) begin : g_cmp
    assign ge[k] = ({1'b0, lin} >= THRESH[k]);
  end

  // binary search over the monotone threshold flags
  always_comb begin
    idx  = '0;
    cand = '0;
    for (int b = CODE_W - 1; b >= 0; b--) begin
      cand = idx | (CODE_W'(1) << b);
      if (ge[cand]) begin
        idx = cand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= idx;
  end

  assign code_o = code_q;

endmodule

// ===== rtl/accumulated_pixel_srgb_encoder_top.sv =====
// ----------------------------------------------------------------------------
// accumulated_pixel_srgb_encoder_top
// Averages accumulated RGB radiance and encodes it to 8-bit sRGB codes.
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// pixel in | start, busy                | red_sum_i, green_sum_i, blue_sum_i
// code out | done_o (one-cycle strobe)  | red_code_o, green_code_o, blue_code_o
// config   | cfg_valid_i, cfg_ready_o   | cfg_data_i (samples per pixel)
//
// One pixel beat per clock while busy is low; codes and done_o pass the input,
// product and code registers after the beat is taken.
// A configuration write runs the reciprocal divider, one quotient bit per
// cycle; busy and !cfg_ready_o are high while it runs.
// Reset sets the sample count to one. The result side cannot stall.
// ----------------------------------------------------------------------------
module accumulated_pixel_srgb_encoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [apse_pkg::SUM_W-1:0]  red_sum_i,
  input  logic signed [apse_pkg::SUM_W-1:0]  green_sum_i,
  input  logic signed [apse_pkg::SUM_W-1:0]  blue_sum_i,
  output logic                               done_o,
  output logic [apse_pkg::CODE_W-1:0]        red_code_o,
  output logic [apse_pkg::CODE_W-1:0]        green_code_o,
  output logic [apse_pkg::CODE_W-1:0]        blue_code_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [apse_pkg::CFG_W-1:0]         cfg_data_i
);
  import apse_pkg::*;

  div_status_t             div_st;
  logic                    accept;
  logic                    in_v_q, in_v_d;
  logic                    prod_v_q, prod_v_d;
  logic                    done_q, done_d;
  logic signed [SUM_W-1:0] red_q, green_q, blue_q;

  apse_recip_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (div_st)
  );

  assign busy        = div_st.busy;
  assign cfg_ready_o = !div_st.busy;
  assign accept      = start && !div_st.busy;

  assign in_v_d   = accept;
  assign prod_v_d = in_v_q;
  assign done_d   = prod_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_v_q   <= in_v_d;
      prod_v_q <= prod_v_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= red_sum_i;
      green_q <= green_sum_i;
      blue_q  <= blue_sum_i;
    end
  end

  apse_chan u_red (
    .clk_i   (clk_i),
    .sum_i   (red_q),
    .recip_i (div_st.recip),
    .code_o  (red_code_o)
  );

  apse_chan u_green (
    .clk_i   (clk_i),
    .sum_i   (green_q),
    .recip_i (div_st.recip),
    .code_o  (green_code_o)
  );

  apse_chan u_blue (
    .clk_i   (clk_i),
    .sum_i   (blue_q),
    .recip_i (div_st.recip),
    .code_o  (blue_code_o)
  );

  assign done_o = done_q;

endmodule

// ===== rtl/apse_checker.sv =====
// ----------------------------------------------------------------------------
// apse_checker
// Port-level checks of the pixel sRGB encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "accumulated_pixel_srgb_encoder_top_macros.svh"

module apse_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic signed [apse_pkg::SUM_W-1:0]  red_sum_i,
  input logic                               done_o,
  input logic [apse_pkg::CODE_W-1:0]        red_code_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o
);
  import apse_pkg::*;

  `APSE_ASSERT(a_beat_to_done, (start && !busy) |-> ##3 done_o, "pixel beat gave no result")
  `APSE_ASSERT(a_neg_is_black, (start && !busy && red_sum_i[SUM_W-1]) |-> ##3 (red_code_o == '0), "negative sum gave nonzero code")
  `APSE_ASSERT(a_cfg_busy, (cfg_valid_i && cfg_ready_o) |=> busy, "config beat did not start divider")
  `APSE_ASSERT(a_busy_blocks_cfg, busy |-> !cfg_ready_o, "config ready while divider busy")

endmodule

bind accumulated_pixel_srgb_encoder_top apse_checker u_apse_checker (.*);
